### hdl/stm_pkg.sv
// Shared types, constants and helper functions of the three-voice tone mixer.
// No dependencies; every other file takes names from here by scope.
`default_nettype none

package stm_pkg;

    localparam int PHASE_BITS    = 32;
    localparam int DUTY_BITS     = 16;
    localparam int VALUE_BITS    = 32;
    localparam int DUR_BITS      = 32;
    localparam int LEVEL_BITS    = 15;
    localparam int SAMPLE_BITS   = 16;
    localparam int NUM_VOICES    = 3;
    localparam int SQ_TERM_BITS  = LEVEL_BITS + 1;
    localparam int TRI_TERM_BITS = LEVEL_BITS + 2;
    localparam int TRI_X_BITS    = PHASE_BITS + 1;
    localparam int TRI_PROD_BITS = LEVEL_BITS + 1 + TRI_X_BITS;
    localparam int TRI_SHIFT     = PHASE_BITS - 3;
    localparam int SUM_BITS      = TRI_TERM_BITS + 1;

    localparam logic [PHASE_BITS-1:0] PHASE_QUARTER = {2'b01, {(PHASE_BITS-2){1'b0}}};
    localparam logic [PHASE_BITS-1:0] PHASE_THREE_QUARTER = {2'b11, {(PHASE_BITS-2){1'b0}}};
    localparam logic [TRI_PROD_BITS-1:0] TRI_BIAS =
        {{(TRI_PROD_BITS-TRI_SHIFT){1'b0}}, {TRI_SHIFT{1'b1}}};

    localparam logic [DUTY_BITS:0] DUTY_FULL_CODE = {1'b1, {DUTY_BITS{1'b0}}};
    localparam logic [VALUE_BITS-1:0] DUTY_FULL_VALUE =
        {{(VALUE_BITS-DUTY_BITS-1){1'b0}}, DUTY_FULL_CODE};
    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX_CODE = {LEVEL_BITS{1'b1}};
    localparam logic [VALUE_BITS-1:0] LEVEL_MAX_VALUE =
        {{(VALUE_BITS-LEVEL_BITS){1'b0}}, LEVEL_MAX_CODE};

    localparam logic [1:0] CH_SQUARE_A = 2'd0;
    localparam logic [1:0] CH_SQUARE_B = 2'd1;
    localparam logic [1:0] CH_TRIANGLE = 2'd2;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        SET_STEP     = 3'd0,
        SET_LENGTH   = 3'd1,
        SET_LEVEL    = 3'd2,
        SET_DUTY     = 3'd3,
        SET_ENABLE   = 3'd4
    } setting_t;

    typedef struct packed {
        op_t                    operation;
        logic [1:0]             channel;
        logic [2:0]             setting;
        logic [VALUE_BITS-1:0]  value;
    } stm_item_t;

    typedef struct packed {
        logic                   tick;
        logic                   write;
        setting_t               setting;
        logic [VALUE_BITS-1:0]  value;
    } stm_voice_cmd_t;

    typedef struct packed {
        logic                           sounding;
        logic signed [SQ_TERM_BITS-1:0] term;
    } stm_sq_out_t;

    typedef struct packed {
        logic                            sounding;
        logic signed [TRI_TERM_BITS-1:0] term;
    } stm_tri_out_t;

    typedef struct packed {
        stm_sq_out_t  square_a;
        stm_sq_out_t  square_b;
        stm_tri_out_t triangle;
    } stm_mix_t;

    function automatic logic [LEVEL_BITS-1:0] sat_level(input logic [VALUE_BITS-1:0] value);
        logic [LEVEL_BITS-1:0] result;
        result = (value > LEVEL_MAX_VALUE) ? LEVEL_MAX_CODE : value[LEVEL_BITS-1:0];
        return result;
    endfunction

    function automatic logic [DUR_BITS-1:0] dec_sat(input logic [DUR_BITS-1:0] count);
        logic [DUR_BITS-1:0] result;
        result = (count != '0) ? count - {{(DUR_BITS-1){1'b0}}, 1'b1} : count;
        return result;
    endfunction

endpackage

`default_nettype wire

### hdl/stm_if.sv
// Valid/ready channel interfaces for request items and sample results.
// Depends on stm_pkg for field widths.
`default_nettype none

interface stm_req_if;
    logic                           valid;
    logic                           ready;
    logic                           operation;
    logic [1:0]                     channel;
    logic [2:0]                     setting;
    logic [stm_pkg::VALUE_BITS-1:0] value;

    modport source (output valid, output operation, output channel, output setting,
                    output value, input ready);
    modport sink   (input valid, input operation, input channel, input setting,
                    input value, output ready);
endinterface

interface stm_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [stm_pkg::SAMPLE_BITS-1:0] sample;
    logic [stm_pkg::NUM_VOICES-1:0]         voices_sounding;

    modport source (output valid, output sample, output voices_sounding, input ready);
    modport sink   (input valid, input sample, input voices_sounding, output ready);
endinterface

`default_nettype wire

### hdl/stm_square_voice.sv
// One square voice: phase accumulator, duration, level, duty and enable state.
// Depends on stm_pkg.
`default_nettype none

module stm_square_voice (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire stm_pkg::stm_voice_cmd_t cmd,
    output stm_pkg::stm_sq_out_t         status
);

    logic [stm_pkg::PHASE_BITS-1:0] phase_reg, phase_next;
    logic [stm_pkg::PHASE_BITS-1:0] step_reg, step_next;
    logic [stm_pkg::DUR_BITS-1:0]   left_reg, left_next;
    logic [stm_pkg::LEVEL_BITS-1:0] level_reg, level_next;
    logic [stm_pkg::DUTY_BITS:0]    duty_reg, duty_next;
    logic                           on_reg, on_next;
    logic                           sounding;
    logic [stm_pkg::PHASE_BITS:0]   threshold;
    logic [stm_pkg::SQ_TERM_BITS-1:0] level_wide;

    assign sounding   = on_reg && (left_reg != '0);
    assign threshold  = {duty_reg, {(stm_pkg::PHASE_BITS-stm_pkg::DUTY_BITS){1'b0}}};
    assign level_wide = {1'b0, level_reg};

    always_comb
    begin
        status.sounding = sounding;
        if (!sounding)
        begin
            status.term = '0;
        end
        else if ({1'b0, phase_reg} < threshold)
        begin
            status.term = $signed(level_wide);
        end
        else
        begin
            status.term = -$signed(level_wide);
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        step_next  = step_reg;
        left_next  = left_reg;
        level_next = level_reg;
        duty_next  = duty_reg;
        on_next    = on_reg;
        if (cmd.tick && sounding)
        begin
            left_next  = left_reg - {{(stm_pkg::DUR_BITS-1){1'b0}}, 1'b1};
            phase_next = phase_reg + step_reg;
        end
        if (cmd.write)
        begin
            unique case (cmd.setting)
                stm_pkg::SET_STEP:     step_next  = cmd.value[stm_pkg::PHASE_BITS-1:0];
                stm_pkg::SET_LENGTH:   left_next  = cmd.value[stm_pkg::DUR_BITS-1:0];
                stm_pkg::SET_LEVEL:    level_next = stm_pkg::sat_level(cmd.value);
                stm_pkg::SET_DUTY:     duty_next  = (cmd.value > stm_pkg::DUTY_FULL_VALUE) ?
                                           stm_pkg::DUTY_FULL_CODE :
                                           cmd.value[stm_pkg::DUTY_BITS:0];
                stm_pkg::SET_ENABLE:   on_next    = (cmd.value != '0);
                default:               on_next    = on_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            step_reg  <= '0;
            left_reg  <= '0;
            level_reg <= '0;
            duty_reg  <= '0;
            on_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
            left_reg  <= left_next;
            level_reg <= level_next;
            duty_reg  <= duty_next;
            on_reg    <= on_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_silent_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.tick && !sounding) |=> ($stable(phase_reg) && $stable(left_reg)))
        else $error("silent square voice moved on tick");
`endif

endmodule

`default_nettype wire

### hdl/stm_triangle_voice.sv
// Triangle voice: phase accumulator with quarter-period restart and the
// level-scaled triangle term. Depends on stm_pkg.
`default_nettype none

module stm_triangle_voice (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire stm_pkg::stm_voice_cmd_t cmd,
    output stm_pkg::stm_tri_out_t        status
);

    logic [stm_pkg::PHASE_BITS-1:0] phase_reg, phase_next;
    logic [stm_pkg::PHASE_BITS-1:0] step_reg, step_next;
    logic [stm_pkg::DUR_BITS-1:0]   left_reg, left_next;
    logic [stm_pkg::LEVEL_BITS-1:0] level_reg, level_next;
    logic                           on_reg, on_next;
    logic                           sounding;
    logic [stm_pkg::PHASE_BITS-1:0] phase_base;
    logic signed [stm_pkg::TRI_X_BITS-1:0]    slope;
    logic signed [stm_pkg::TRI_PROD_BITS-1:0] product;
    logic [stm_pkg::TRI_PROD_BITS-1:0]        biased;

    assign sounding = on_reg && (left_reg != '0);

    always_comb
    begin
        if (phase_reg[stm_pkg::PHASE_BITS-1])
        begin
            slope = $signed({1'b0, stm_pkg::PHASE_THREE_QUARTER}) - $signed({1'b0, phase_reg});
        end
        else
        begin
            slope = $signed({1'b0, phase_reg}) - $signed({1'b0, stm_pkg::PHASE_QUARTER});
        end
    end

    assign product = $signed({1'b0, level_reg}) * slope;
    assign biased  = $unsigned(product) +
                     (product[stm_pkg::TRI_PROD_BITS-1] ? stm_pkg::TRI_BIAS : '0);

    always_comb
    begin
        status.sounding = sounding;
        status.term     = sounding ?
                          $signed(biased[stm_pkg::TRI_SHIFT +: stm_pkg::TRI_TERM_BITS]) : '0;
    end

    assign phase_base = sounding ? phase_reg : stm_pkg::PHASE_QUARTER;

    always_comb
    begin
        phase_next = phase_reg;
        step_next  = step_reg;
        left_next  = left_reg;
        level_next = level_reg;
        on_next    = on_reg;
        if (cmd.tick)
        begin
            left_next  = stm_pkg::dec_sat(left_reg);
            phase_next = phase_base + step_reg;
        end
        if (cmd.write)
        begin
            unique case (cmd.setting)
                stm_pkg::SET_STEP:     step_next  = cmd.value[stm_pkg::PHASE_BITS-1:0];
                stm_pkg::SET_LENGTH:   left_next  = cmd.value[stm_pkg::DUR_BITS-1:0];
                stm_pkg::SET_LEVEL:    level_next = stm_pkg::sat_level(cmd.value);
                stm_pkg::SET_ENABLE:   on_next    = (cmd.value != '0);
                default:               on_next    = on_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= stm_pkg::PHASE_QUARTER;
            step_reg  <= '0;
            left_reg  <= '0;
            level_reg <= '0;
            on_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
            left_reg  <= left_next;
            level_reg <= level_next;
            on_reg    <= on_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_silent_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.tick && !sounding) |=>
            (phase_reg == stm_pkg::PHASE_QUARTER + $past(step_reg)))
        else $error("silent triangle voice did not restart at a quarter period");
`endif

endmodule

`default_nettype wire

### hdl/stm_mixer.sv
// Sums the three voice terms, saturates to 16 bits and holds the result item
// in the output register. Depends on stm_pkg and stm_rsp_if.
`default_nettype none

module stm_mixer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire stm_pkg::stm_mix_t mix,
    output logic                   slot_free,
    stm_rsp_if.source              rsp
);

    logic                                    valid_reg, valid_next;
    logic signed [stm_pkg::SAMPLE_BITS-1:0]  sample_reg, sample_next;
    logic [stm_pkg::NUM_VOICES-1:0]          voices_reg, voices_next;
    logic signed [stm_pkg::SUM_BITS-1:0]     sum;
    logic [stm_pkg::SUM_BITS-stm_pkg::SAMPLE_BITS:0] top_bits;

    assign slot_free = !valid_reg || rsp.ready;

    assign sum = $signed({{(stm_pkg::SUM_BITS-stm_pkg::SQ_TERM_BITS)
                            {mix.square_a.term[stm_pkg::SQ_TERM_BITS-1]}}, mix.square_a.term})
               + $signed({{(stm_pkg::SUM_BITS-stm_pkg::SQ_TERM_BITS)
                            {mix.square_b.term[stm_pkg::SQ_TERM_BITS-1]}}, mix.square_b.term})
               + $signed({{(stm_pkg::SUM_BITS-stm_pkg::TRI_TERM_BITS)
                            {mix.triangle.term[stm_pkg::TRI_TERM_BITS-1]}}, mix.triangle.term});

    assign top_bits = sum[stm_pkg::SUM_BITS-1:stm_pkg::SAMPLE_BITS-1];

    always_comb
    begin
        if ((top_bits == '0) || (top_bits == '1))
        begin
            sample_next = sum[stm_pkg::SAMPLE_BITS-1:0];
        end
        else if (sum[stm_pkg::SUM_BITS-1])
        begin
            sample_next = {1'b1, {(stm_pkg::SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            sample_next = {1'b0, {(stm_pkg::SAMPLE_BITS-1){1'b1}}};
        end
        voices_next = {mix.triangle.sounding, mix.square_b.sounding, mix.square_a.sounding};
        valid_next  = load || (valid_reg && !rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sample_reg <= sample_next;
            voices_reg <= voices_next;
        end
    end

    assign rsp.valid           = valid_reg;
    assign rsp.sample          = sample_reg;
    assign rsp.voices_sounding = voices_reg;

endmodule

`default_nettype wire

### hdl/square_triangle_tone_mixer.sv
// Three-voice tone mixer: input register, two square voices, one triangle voice, mixer.
// A tick in the input register waits for a free output slot; then its sample is registered.
// Throughput: one item per cycle, but ticks wait for a free output slot; writes never do.
// Reset clears the pipeline, all voice settings and phases; triangle phase restarts at a
// quarter period. Depends on stm_pkg, stm_if and the stm_* voice and mixer modules.
`default_nettype none

module square_triangle_tone_mixer (
    input  wire logic clk,
    input  wire logic rst_n,
    stm_req_if.sink   req,
    stm_rsp_if.source rsp
);

    logic                    s1_valid_reg, s1_valid_next;
    stm_pkg::stm_item_t      s1_item_reg;
    logic                    s1_advance;
    logic                    slot_free;
    logic                    tick;
    logic                    write;
    stm_pkg::stm_voice_cmd_t cmd_a, cmd_b, cmd_t;
    stm_pkg::stm_sq_out_t    status_a, status_b;
    stm_pkg::stm_tri_out_t   status_t;
    stm_pkg::stm_mix_t       mix;

    assign s1_advance = s1_valid_reg &&
                        ((s1_item_reg.operation == stm_pkg::OP_WRITE) || slot_free);
    assign req.ready  = !s1_valid_reg || s1_advance;
    assign tick       = s1_advance && (s1_item_reg.operation == stm_pkg::OP_TICK);
    assign write      = s1_advance && (s1_item_reg.operation == stm_pkg::OP_WRITE);

    always_comb
    begin
        s1_valid_next = req.valid || (s1_valid_reg && !s1_advance);
        cmd_a.tick    = tick;
        cmd_a.write   = write && (s1_item_reg.channel == stm_pkg::CH_SQUARE_A);
        cmd_a.setting = stm_pkg::setting_t'(s1_item_reg.setting);
        cmd_a.value   = s1_item_reg.value;
        cmd_b         = cmd_a;
        cmd_b.write   = write && (s1_item_reg.channel == stm_pkg::CH_SQUARE_B);
        cmd_t         = cmd_a;
        cmd_t.write   = write && (s1_item_reg.channel == stm_pkg::CH_TRIANGLE);
        mix.square_a  = status_a;
        mix.square_b  = status_b;
        mix.triangle  = status_t;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_item_reg.operation <= stm_pkg::op_t'(req.operation);
            s1_item_reg.channel   <= req.channel;
            s1_item_reg.setting   <= req.setting;
            s1_item_reg.value     <= req.value;
        end
    end

    stm_square_voice u_square_a (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_a),
        .status (status_a)
    );

    stm_square_voice u_square_b (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_b),
        .status (status_b)
    );

    stm_triangle_voice u_triangle (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_t),
        .status (status_t)
    );

    stm_mixer u_mixer (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (tick),
        .mix       (mix),
        .slot_free (slot_free),
        .rsp       (rsp)
    );

`ifndef NO_ASSERTIONS
    a_tick_gives_item: assert property (@(posedge clk) disable iff (!rst_n)
        tick |=> rsp.valid)
        else $error("tick item left no result item");
    a_write_no_item: assert property (@(posedge clk) disable iff (!rst_n)
        (write && !rsp.valid) |=> !rsp.valid)
        else $error("write item produced a result item");
    a_tick_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        tick |-> (!rsp.valid || rsp.ready))
        else $error("tick advanced over an untaken result item");
`endif

endmodule

`default_nettype wire

### tb/sv/square_triangle_tone_mixer_tb.sv
// Self-checking bench for the three-voice tone mixer: directed and random
// setting writes and ticks, each sample compared with a cycle-free voice model.
// Depends on stm_pkg, stm_if and the square_triangle_tone_mixer RTL.
`timescale 1ns / 1ps

module square_triangle_tone_mixer_tb;

    localparam int          CYCLE_LIMIT      = 1_000_000;
    localparam int          RANDOM_ITEMS     = 1500;
    localparam int          DRAIN_CYCLES     = 8;
    localparam logic [1:0]  CH_UNUSED        = 2'd3;
    localparam logic [2:0]  SET_UNUSED_FIRST = 3'd5;
    localparam logic [2:0]  SET_UNUSED_LAST  = 3'd7;

    typedef struct {
        logic signed [stm_pkg::SAMPLE_BITS-1:0] sample;
        logic [stm_pkg::NUM_VOICES-1:0]         voices;
    } mix_result_t;

    logic clk = 1'b0;
    logic rst_n;

    stm_req_if req_ch ();
    stm_rsp_if rsp_ch ();

    square_triangle_tone_mixer uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #1 clk = ~clk;

    logic [stm_pkg::PHASE_BITS-1:0] voice_phase  [stm_pkg::NUM_VOICES];
    logic [stm_pkg::PHASE_BITS-1:0] voice_step   [stm_pkg::NUM_VOICES];
    logic [stm_pkg::DUR_BITS-1:0]   voice_left   [stm_pkg::NUM_VOICES];
    logic [stm_pkg::LEVEL_BITS-1:0] voice_level  [stm_pkg::NUM_VOICES];
    logic [stm_pkg::DUTY_BITS:0]    voice_duty   [2];
    logic                           voice_enable [stm_pkg::NUM_VOICES];

    mix_result_t mixed_samples[$];

    int  errors       = 0;
    int  cycles       = 0;
    int  n_ticks      = 0;
    int  n_writes     = 0;
    int  n_ignored    = 0;
    int  n_clipped    = 0;
    int  n_applied    = 0;
    int  voice_hits [stm_pkg::NUM_VOICES];
    bit  steady       = 1'b0;

    function automatic longint triangle_value(input logic [stm_pkg::PHASE_BITS-1:0] p,
                                              input logic [stm_pkg::LEVEL_BITS-1:0] amp);
        longint full;
        longint pos;
        longint gain;
        longint num;
        full = 64'sd1 << stm_pkg::PHASE_BITS;
        pos  = p;
        gain = amp;
        if (pos < (full >>> 1))
            num = 8 * pos - 2 * full;
        else
            num = 6 * full - 8 * pos;
        return (gain * num) / full;
    endfunction

    task automatic clear_voices();
        for (int v = 0; v < stm_pkg::NUM_VOICES; v++)
        begin
            voice_phase[v]  = '0;
            voice_step[v]   = '0;
            voice_left[v]   = '0;
            voice_level[v]  = '0;
            voice_enable[v] = 1'b0;
            voice_hits[v]   = 0;
        end
        voice_duty[0]  = '0;
        voice_duty[1]  = '0;
        voice_phase[2] = stm_pkg::PHASE_QUARTER;
    endtask

    task automatic apply_setting(input logic [1:0] ch, input logic [2:0] sel,
                                 input logic [stm_pkg::VALUE_BITS-1:0] val);
        bit taken;
        taken = 1'b1;
        if (ch == CH_UNUSED)
            taken = 1'b0;
        else
        begin
            case (stm_pkg::setting_t'(sel))
                stm_pkg::SET_STEP:   voice_step[ch] = val[stm_pkg::PHASE_BITS-1:0];
                stm_pkg::SET_LENGTH: voice_left[ch] = val;
                stm_pkg::SET_LEVEL:
                    voice_level[ch] = (val > stm_pkg::LEVEL_MAX_VALUE) ?
                                      stm_pkg::LEVEL_MAX_CODE : val[stm_pkg::LEVEL_BITS-1:0];
                stm_pkg::SET_DUTY:
                begin
                    if (ch == stm_pkg::CH_TRIANGLE)
                        taken = 1'b0;
                    else
                        voice_duty[ch] = (val > stm_pkg::DUTY_FULL_VALUE) ?
                                         stm_pkg::DUTY_FULL_CODE : val[stm_pkg::DUTY_BITS:0];
                end
                stm_pkg::SET_ENABLE: voice_enable[ch] = (val != '0);
                default:             taken = 1'b0;
            endcase
        end
        if (taken)
        begin
            n_writes++;
            n_applied++;
        end
        else
            n_ignored++;
    endtask

    task automatic mix_next_sample();
        int          sum;
        longint      thr;
        longint      pos;
        mix_result_t res;
        sum = 0;
        res.voices = '0;
        for (int v = 0; v < 2; v++)
        begin
            if (voice_enable[v] && voice_left[v] != '0)
            begin
                res.voices[v] = 1'b1;
                voice_hits[v]++;
                thr = voice_duty[v];
                thr = thr << (stm_pkg::PHASE_BITS - stm_pkg::DUTY_BITS);
                pos = voice_phase[v];
                if (pos < thr)
                    sum += int'(voice_level[v]);
                else
                    sum -= int'(voice_level[v]);
                voice_left[v]--;
                voice_phase[v] = voice_phase[v] + voice_step[v];
            end
        end
        if (voice_enable[2] && voice_left[2] != '0)
        begin
            res.voices[2] = 1'b1;
            voice_hits[2]++;
            sum += int'(triangle_value(voice_phase[2], voice_level[2]));
        end
        else
            voice_phase[2] = stm_pkg::PHASE_QUARTER;
        if (voice_left[2] != '0)
            voice_left[2]--;
        voice_phase[2] = voice_phase[2] + voice_step[2];
        if (sum > 32767 || sum < -32768)
            n_clipped++;
        if (sum > 32767)
            sum = 32767;
        if (sum < -32768)
            sum = -32768;
        res.sample = sum[stm_pkg::SAMPLE_BITS-1:0];
        mixed_samples.push_back(res);
        n_ticks++;
        n_applied++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input stm_pkg::op_t op, input logic [1:0] ch,
                             input logic [2:0] sel,
                             input logic [stm_pkg::VALUE_BITS-1:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.channel   <= ch;
        req_ch.setting   <= sel;
        req_ch.value     <= val;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        if (op == stm_pkg::OP_TICK)
            mix_next_sample();
        else
            apply_setting(ch, sel, val);
    endtask

    task automatic tick();
        send_item(stm_pkg::OP_TICK, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                  $urandom);
    endtask

    task automatic write(input logic [1:0] ch, input stm_pkg::setting_t sel,
                         input logic [stm_pkg::VALUE_BITS-1:0] val);
        send_item(stm_pkg::OP_WRITE, ch, sel, val);
    endtask

    function automatic logic [stm_pkg::VALUE_BITS-1:0] pick_value(input stm_pkg::setting_t sel);
        int r;
        r = $urandom_range(0, 99);
        case (sel)
            stm_pkg::SET_STEP:
                if (r < 50)
                    return $urandom;
                else if (r < 80)
                    return $urandom_range(0, 32'h0400_0000);
                else
                    case ($urandom_range(0, 3))
                        0:       return '0;
                        1:       return '1;
                        2:       return stm_pkg::PHASE_THREE_QUARTER;
                        default: return stm_pkg::PHASE_QUARTER;
                    endcase
            stm_pkg::SET_LENGTH:
                if (r < 70)
                    return $urandom_range(1, 48);
                else if (r < 85)
                    return '0;
                else
                    return $urandom;
            stm_pkg::SET_LEVEL:
                if (r < 70)
                    return $urandom_range(0, 32767);
                else if (r < 85)
                    return stm_pkg::LEVEL_MAX_VALUE;
                else
                    return $urandom;
            stm_pkg::SET_DUTY:
                if (r < 70)
                    return $urandom_range(0, 65536);
                else if (r < 85)
                    return (r & 1) ? stm_pkg::DUTY_FULL_VALUE : '0;
                else
                    return $urandom;
            default:
                if (r < 45)
                    return 1;
                else if (r < 70)
                    return '0;
                else
                    return $urandom;
        endcase
    endfunction

    task automatic program_voice(input logic [1:0] ch);
        write(ch, stm_pkg::SET_STEP, pick_value(stm_pkg::SET_STEP));
        write(ch, stm_pkg::SET_LENGTH, pick_value(stm_pkg::SET_LENGTH));
        write(ch, stm_pkg::SET_LEVEL, pick_value(stm_pkg::SET_LEVEL));
        if (ch != stm_pkg::CH_TRIANGLE)
            write(ch, stm_pkg::SET_DUTY, pick_value(stm_pkg::SET_DUTY));
        write(ch, stm_pkg::SET_ENABLE,
              ($urandom_range(0, 9) == 0) ? '0 : pick_value(stm_pkg::SET_ENABLE));
    endtask

    task automatic test_reset_state();
        tick();
        tick();
    endtask

    task automatic test_square_clipping();
        write(stm_pkg::CH_SQUARE_A, stm_pkg::SET_LEVEL, '1);
        write(stm_pkg::CH_SQUARE_A, stm_pkg::SET_DUTY, '1);
        write(stm_pkg::CH_SQUARE_A, stm_pkg::SET_LENGTH, 2);
        write(stm_pkg::CH_SQUARE_A, stm_pkg::SET_ENABLE, 32'h8000_0000);
        write(stm_pkg::CH_SQUARE_B, stm_pkg::SET_LEVEL, stm_pkg::LEVEL_MAX_VALUE);
        write(stm_pkg::CH_SQUARE_B, stm_pkg::SET_DUTY, stm_pkg::DUTY_FULL_VALUE);
        write(stm_pkg::CH_SQUARE_B, stm_pkg::SET_LENGTH, '1);
        write(stm_pkg::CH_SQUARE_B, stm_pkg::SET_STEP, '1);
        write(stm_pkg::CH_SQUARE_B, stm_pkg::SET_ENABLE, 1);
        tick();
    endtask

    task automatic test_triangle_sweep();
        write(stm_pkg::CH_TRIANGLE, stm_pkg::SET_LEVEL, stm_pkg::LEVEL_MAX_VALUE);
        write(stm_pkg::CH_TRIANGLE, stm_pkg::SET_STEP, stm_pkg::PHASE_QUARTER);
        write(stm_pkg::CH_TRIANGLE, stm_pkg::SET_LENGTH, 3);
        write(stm_pkg::CH_TRIANGLE, stm_pkg::SET_DUTY, 5);
        write(stm_pkg::CH_TRIANGLE, stm_pkg::SET_ENABLE, 1);
        write(stm_pkg::CH_SQUARE_B, stm_pkg::SET_DUTY, '0);
        repeat (5) tick();
    endtask

    task automatic test_ignored_writes();
        send_item(stm_pkg::OP_WRITE, CH_UNUSED, stm_pkg::SET_LEVEL, '1);
        send_item(stm_pkg::OP_WRITE, stm_pkg::CH_SQUARE_A, SET_UNUSED_FIRST, '1);
        send_item(stm_pkg::OP_WRITE, stm_pkg::CH_SQUARE_B, SET_UNUSED_LAST, '0);
        write(stm_pkg::CH_SQUARE_B, stm_pkg::SET_ENABLE, '0);
        tick();
    endtask

    task automatic test_random_mix(input int target);
        int start;
        int r;
        start = n_applied;
        while (n_applied - start < target)
        begin
            if ($urandom_range(0, 59) == 0)
                steady = !steady;
            r = $urandom_range(0, 99);
            if (r < 15)
                program_voice(2'($urandom_range(0, 2)));
            else if (r < 60)
                repeat ($urandom_range(1, 8)) tick();
            else if (r < 93)
            begin
                logic [1:0]        ch;
                stm_pkg::setting_t sel;
                ch  = 2'($urandom_range(0, 2));
                sel = stm_pkg::setting_t'(3'($urandom_range(0, 4)));
                write(ch, sel, pick_value(sel));
            end
            else
                send_item(stm_pkg::OP_WRITE,
                          ($urandom_range(0, 1) != 0) ? CH_UNUSED : 2'($urandom_range(0, 2)),
                          3'($urandom_range(SET_UNUSED_FIRST, SET_UNUSED_LAST)), $urandom);
        end
        steady = 1'b0;
    endtask

    initial
    begin : rsp_backpressure
        int stall;
        stall = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                rsp_ch.ready <= 1'b0;
            else if (stall > 0)
            begin
                stall--;
                rsp_ch.ready <= 1'b0;
            end
            else if (steady || $urandom_range(0, 99) < 70)
                rsp_ch.ready <= 1'b1;
            else
            begin
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                    : $urandom_range(0, 2);
                rsp_ch.ready <= 1'b0;
            end
        end
    end

    initial
    begin : sample_checker
        mix_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                if (mixed_samples.size() == 0)
                begin
                    $error("sample item with none outstanding: sample %0d voices %b",
                           rsp_ch.sample, rsp_ch.voices_sounding);
                    errors++;
                end
                else
                begin
                    want = mixed_samples.pop_front();
                    if (rsp_ch.sample !== want.sample)
                    begin
                        $error("sample: expected %0d, actual %0d", want.sample,
                               rsp_ch.sample);
                        errors++;
                    end
                    if (rsp_ch.voices_sounding !== want.voices)
                    begin
                        $error("voices_sounding: expected %b, actual %b", want.voices,
                               rsp_ch.voices_sounding);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("square_triangle_tone_mixer_tb: FAIL");
        $finish;
    end

    initial
    begin
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.operation <= stm_pkg::OP_TICK;
        req_ch.channel   <= stm_pkg::CH_SQUARE_A;
        req_ch.setting   <= stm_pkg::SET_STEP;
        req_ch.value     <= '0;
        clear_voices();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_square_clipping();
        test_triangle_sweep();
        test_ignored_writes();
        test_random_mix(RANDOM_ITEMS);

        req_ch.valid <= 1'b0;
        while (mixed_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mixed_samples.size() != 0)
        begin
            $error("%0d sample items never arrived", mixed_samples.size());
            errors++;
        end

        $display("covered %0d ticks, %0d setting writes, %0d ignored writes, %0d clipped sums",
                 n_ticks, n_writes, n_ignored, n_clipped);
        $display("voices sounding on %0d / %0d / %0d ticks, %0d mismatches",
                 voice_hits[0], voice_hits[1], voice_hits[2], errors);
        if (errors == 0)
            $display("square_triangle_tone_mixer_tb: PASS");
        else
            $display("square_triangle_tone_mixer_tb: FAIL");
        $finish;
    end

endmodule

### sim.f
hdl/stm_pkg.sv
hdl/stm_if.sv
hdl/stm_square_voice.sv
hdl/stm_triangle_voice.sv
hdl/stm_mixer.sv
hdl/square_triangle_tone_mixer.sv
tb/sv/square_triangle_tone_mixer_tb.sv
